@@ hw/rtl/sfhr_pkg.sv @@
// Package for the serial frame handshake receiver.
// Holds frame constants, result and job codes, and the structs shared by all modules.
// No dependencies.
package sfhr_pkg;

  localparam int unsigned FRAME_LEN   = 5;
  localparam int unsigned FILL_W      = $clog2(FRAME_LEN);
  localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned RES_CNT_W   = $clog2(FRAME_LEN);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] CODE_ACK_WORD = 32'h7FFF_FFFF;
  localparam logic [31:0] DATA_ACK_WORD = 32'h3FFF_FFFF;
  localparam logic [7:0]  CH_CR         = 8'h0D;
  localparam logic [7:0]  CH_LF         = 8'h0A;

  localparam logic [7:0] PFX_A_0 = 8'h41;
  localparam logic [7:0] PFX_A_1 = 8'h73;
  localparam logic [7:0] PFX_A_2 = 8'h73;
  localparam logic [7:0] PFX_A_3 = 8'h65;
  localparam logic [7:0] PFX_B_0 = 8'h50;
  localparam logic [7:0] PFX_B_1 = 8'h53;
  localparam logic [7:0] PFX_B_2 = 8'h4F;
  localparam logic [7:0] PFX_B_3 = 8'h43;

  typedef enum logic [1:0] {
    CFG_OWN_ADDR   = 2'd0,
    CFG_MOTOR_ADDR = 2'd1,
    CFG_IO_ADDR    = 2'd2,
    CFG_ACC_CODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_SEND    = 3'd1,
    KIND_DELIVER = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_ACK     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_DUP_ACK      = 2'd1,
    ERR_CODE_REJ     = 2'd2,
    ERR_UNKNOWN_ADDR = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    JOB_TEXT,
    JOB_PREFIX,
    JOB_ERROR,
    JOB_ACK,
    JOB_CODE_ACK,
    JOB_DELIVER
  } job_op_e;

  typedef struct packed {
    logic [7:0]  own_addr;
    logic [7:0]  motor_addr;
    logic [7:0]  io_addr;
    logic [31:0] acc_code;
  } cfg_t;

  typedef struct packed {
    job_op_e                     op;
    err_e                        err;
    logic [FRAME_LEN-1:0][7:0]   bytes;
    logic [7:0]                  motor;
    logic [31:0]                 code;
    logic [31:0]                 data;
    logic                        code_ack;
    logic                        data_ack;
  } job_t;

endpackage

@@ hw/rtl/sfhr_if.sv @@
// Stream interfaces for the serial frame handshake receiver.
// Received byte channel and result channel, each with valid/ready. No dependencies.
interface sfhr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfhr_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         text_byte;
  logic [7:0]         tx_addr;
  logic [31:0]        tx_word;
  logic [31:0]        cmd_code;
  logic signed [31:0] cmd_data;
  logic [1:0]         error_code;
  logic               code_ack_seen;
  logic               data_ack_seen;
  logic               last;

  modport source (output valid, output kind, output text_byte, output tx_addr, output tx_word,
                  output cmd_code, output cmd_data, output error_code, output code_ack_seen,
                  output data_ack_seen, output last, input ready);
  modport sink (input valid, input kind, input text_byte, input tx_addr, input tx_word,
                input cmd_code, input cmd_data, input error_code, input code_ack_seen,
                input data_ack_seen, input last, output ready);
endinterface

@@ hw/rtl/serial_frame_handshake_receiver.sv @@
// Top level of the serial frame handshake receiver.
// Holds the configuration registers and joins front end, job queue and back end.
// Depends on sfhr_pkg, sfhr_if, sfhr_front, sfhr_queue and sfhr_back.
//
// Usage:
//   rx_i carries one received byte per transfer (valid/ready). res_o carries the
//   result transfers; every byte causes zero to five of them, the final one
//   marked by last. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while no byte is in flight; a write lands at the next clock edge.
//   A byte's job enters the queue on its transfer; the back end then registers
//   its first result into res_o. Throughput: one byte per cycle while the job queue
//   has room; the back end sends one result per cycle while res_o is ready, and a
//   text-prefix frame gives five results, a delivered command two. The queue depth
//   (QUEUE_DEPTH jobs) sets how far the front end runs ahead.
//   Reset clears the frame fill, text mode, handshake flags and held code, and
//   loads the configuration reset values; no clearing pass is needed.
//   When the receiver stalls res_o, the current result holds, the queue fills,
//   and rx_i.ready drops until room frees up.
module serial_frame_handshake_receiver import sfhr_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  sfhr_rx_if.sink     rx_i,
  sfhr_res_if.source  res_o
);

  cfg_t cfg_q;
  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr   <= 8'd0;
      cfg_q.motor_addr <= 8'd1;
      cfg_q.io_addr    <= 8'd2;
      cfg_q.acc_code   <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_ADDR:   cfg_q.own_addr   <= cfg_wdata_i[7:0];
        CFG_MOTOR_ADDR: cfg_q.motor_addr <= cfg_wdata_i[7:0];
        CFG_IO_ADDR:    cfg_q.io_addr    <= cfg_wdata_i[7:0];
        CFG_ACC_CODE:   cfg_q.acc_code   <= cfg_wdata_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  sfhr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .rx_valid_i   (rx_i.valid),
    .rx_byte_i    (rx_i.rx_byte),
    .queue_full_i (queue_full),
    .rx_ready_o   (rx_i.ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  sfhr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  sfhr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

@@ hw/rtl/sfhr_front.sv @@
// Front end: collects bytes into frames, tracks text mode and handshake state.
// Pushes one job per byte that causes results. Depends on sfhr_pkg.
module sfhr_front import sfhr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   rx_valid_i,
  input  logic   [7:0] rx_byte_i,
  input  logic   queue_full_i,
  output logic   rx_ready_o,
  output logic   push_o,
  output job_t   job_o
);

  logic [7:0]        store_q [STORE_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              text_mode_q, text_mode_d;
  logic              saw_cr_q, saw_cr_d;
  logic              code_ack_q, code_ack_d;
  logic              data_ack_q, data_ack_d;
  logic              awaiting_q, awaiting_d;
  logic [31:0]       held_code_q, held_code_d;
  logic              accept;
  logic              frame_done;

  assign rx_ready_o = !queue_full_i;
  assign accept     = rx_valid_i && !queue_full_i;
  assign frame_done = !text_mode_q && (fill_q == FILL_W'(FRAME_LEN - 1));

  always_comb begin
    logic [31:0] word;
    logic        pfx_a;
    logic        pfx_b;
    logic        emit;
    word        = {store_q[1], store_q[2], store_q[3], rx_byte_i};
    pfx_a       = (store_q[0] == PFX_A_0) && (store_q[1] == PFX_A_1) &&
                  (store_q[2] == PFX_A_2) && (store_q[3] == PFX_A_3);
    pfx_b       = (store_q[0] == PFX_B_0) && (store_q[1] == PFX_B_1) &&
                  (store_q[2] == PFX_B_2) && (store_q[3] == PFX_B_3);
    emit        = 1'b0;
    fill_d      = fill_q;
    text_mode_d = text_mode_q;
    saw_cr_d    = saw_cr_q;
    code_ack_d  = code_ack_q;
    data_ack_d  = data_ack_q;
    awaiting_d  = awaiting_q;
    held_code_d = held_code_q;
    job_o       = '0;
    job_o.op    = JOB_TEXT;
    job_o.err   = ERR_NONE;
    job_o.bytes = {rx_byte_i, store_q[3], store_q[2], store_q[1], store_q[0]};
    job_o.motor = cfg_i.motor_addr;
    job_o.code  = held_code_q;
    job_o.data  = word;

    if (text_mode_q) begin
      emit     = 1'b1;
      saw_cr_d = (rx_byte_i == CH_CR);
      if (rx_byte_i == CH_LF && saw_cr_q) begin
        text_mode_d = 1'b0;
      end
      job_o.op    = JOB_TEXT;
      job_o.bytes = '0;
      job_o.bytes[0] = rx_byte_i;
    end else if (!frame_done) begin
      fill_d = fill_q + FILL_W'(1);
    end else begin
      fill_d = '0;
      if (pfx_a || pfx_b) begin
        text_mode_d = 1'b1;
        emit        = 1'b1;
        job_o.op    = JOB_PREFIX;
      end else if (store_q[0] == cfg_i.io_addr || store_q[0] == cfg_i.motor_addr) begin
        emit = 1'b0;
      end else if (store_q[0] != cfg_i.own_addr) begin
        emit       = 1'b1;
        job_o.op   = JOB_ERROR;
        job_o.err  = ERR_UNKNOWN_ADDR;
        code_ack_d = 1'b0;
        data_ack_d = 1'b0;
        awaiting_d = 1'b0;
      end else if (word == CODE_ACK_WORD || word == DATA_ACK_WORD) begin
        emit = 1'b1;
        if ((word == CODE_ACK_WORD) ? code_ack_q : data_ack_q) begin
          job_o.op   = JOB_ERROR;
          job_o.err  = ERR_DUP_ACK;
          code_ack_d = 1'b0;
          data_ack_d = 1'b0;
          awaiting_d = 1'b0;
        end else begin
          job_o.op = JOB_ACK;
          if (word == CODE_ACK_WORD) begin
            code_ack_d = 1'b1;
          end else begin
            data_ack_d = 1'b1;
          end
        end
      end else if (!awaiting_q) begin
        emit = 1'b1;
        if (word == cfg_i.acc_code) begin
          job_o.op    = JOB_CODE_ACK;
          held_code_d = word;
          awaiting_d  = 1'b1;
        end else begin
          job_o.op   = JOB_ERROR;
          job_o.err  = ERR_CODE_REJ;
          code_ack_d = 1'b0;
          data_ack_d = 1'b0;
          awaiting_d = 1'b0;
        end
      end else begin
        emit       = 1'b1;
        job_o.op   = JOB_DELIVER;
        awaiting_d = 1'b0;
      end
    end
    job_o.code_ack = code_ack_d;
    job_o.data_ack = data_ack_d;
    push_o         = accept && emit;
  end

  always_ff @(posedge clk_i) begin
    if (accept && !text_mode_q && !frame_done) begin
      store_q[fill_q[STORE_IDX_W-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      text_mode_q <= 1'b0;
      saw_cr_q    <= 1'b0;
      code_ack_q  <= 1'b0;
      data_ack_q  <= 1'b0;
      awaiting_q  <= 1'b0;
      held_code_q <= '0;
    end else if (accept) begin
      fill_q      <= fill_d;
      text_mode_q <= text_mode_d;
      saw_cr_q    <= saw_cr_d;
      code_ack_q  <= code_ack_d;
      data_ack_q  <= data_ack_d;
      awaiting_q  <= awaiting_d;
      held_code_q <= held_code_d;
    end
  end

endmodule

@@ hw/rtl/sfhr_queue.sv @@
// Job queue between the front and back ends of the receiver.
// Small register FIFO of job_t entries. Depends on sfhr_pkg.
module sfhr_queue import sfhr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
    logic [AW-1:0] res;
    res = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    return res;
  endfunction

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/sfhr_back.sv @@
// Back end: expands each queued job into its result transfers.
// Drives the registered result channel. Depends on sfhr_pkg and sfhr_if.
module sfhr_back import sfhr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  job_t          job_i,
  output logic          pop_o,
  sfhr_res_if.source    res_o
);

  logic [RES_CNT_W-1:0] idx_q;
  logic [RES_CNT_W-1:0] n_res;
  logic                 load;
  logic                 is_last;
  kind_e                kind;
  err_e                 err;
  logic [7:0]           text_byte;
  logic [7:0]           tx_addr;
  logic [31:0]          tx_word;
  logic [31:0]          cmd_code;
  logic [31:0]          cmd_data;

  assign load    = job_valid_i && (!res_o.valid || res_o.ready);
  assign is_last = (idx_q == n_res - RES_CNT_W'(1));
  assign pop_o   = load && is_last;

  always_comb begin
    n_res     = RES_CNT_W'(1);
    kind      = KIND_TEXT;
    err       = ERR_NONE;
    text_byte = '0;
    tx_addr   = '0;
    tx_word   = '0;
    cmd_code  = '0;
    cmd_data  = '0;
    unique case (job_i.op)
      JOB_TEXT: begin
        text_byte = job_i.bytes[0];
      end
      JOB_PREFIX: begin
        n_res     = RES_CNT_W'(FRAME_LEN);
        text_byte = job_i.bytes[idx_q];
      end
      JOB_ERROR: begin
        kind = KIND_ERROR;
        err  = job_i.err;
      end
      JOB_ACK: begin
        kind = KIND_ACK;
      end
      JOB_CODE_ACK: begin
        kind    = KIND_SEND;
        tx_addr = job_i.motor;
        tx_word = CODE_ACK_WORD;
      end
      JOB_DELIVER: begin
        n_res = RES_CNT_W'(2);
        if (idx_q == '0) begin
          kind    = KIND_SEND;
          tx_addr = job_i.motor;
          tx_word = DATA_ACK_WORD;
        end else begin
          kind     = KIND_DELIVER;
          cmd_code = job_i.code;
          cmd_data = job_i.data;
        end
      end
      default: begin
        kind = KIND_TEXT;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_o.kind          <= kind;
      res_o.text_byte     <= text_byte;
      res_o.tx_addr       <= tx_addr;
      res_o.tx_word       <= tx_word;
      res_o.cmd_code      <= cmd_code;
      res_o.cmd_data      <= cmd_data;
      res_o.error_code    <= err;
      res_o.code_ack_seen <= job_i.code_ack;
      res_o.data_ack_seen <= job_i.data_ack;
      res_o.last          <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.valid <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        res_o.valid <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + RES_CNT_W'(1);
      end else if (res_o.ready) begin
        res_o.valid <= 1'b0;
      end
    end
  end

endmodule

@@ bench/serial_frame_handshake_receiver_tb.sv @@
// Self-checking bench for serial_frame_handshake_receiver: random and directed byte streams,
// with a scoreboard that predicts every result transfer and compares it field by field.
// Depends on sfhr_pkg, sfhr_if and the receiver RTL.
`timescale 1ns / 1ps

module serial_frame_handshake_receiver_tb;
  import sfhr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 60;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         text_byte;
    logic [7:0]         tx_addr;
    logic [31:0]        tx_word;
    logic [31:0]        cmd_code;
    logic signed [31:0] cmd_data;
    logic [1:0]         error_code;
    logic               code_ack_seen;
    logic               data_ack_seen;
    logic               last;
  } result_t;

  class handshake_scoreboard;
    logic [7:0]  own_addr;
    logic [7:0]  motor_addr;
    logic [7:0]  io_addr;
    logic [31:0] acc_code;
    logic [7:0]  frame_bytes[FRAME_LEN];
    int unsigned fill;
    bit          text_mode;
    bit          saw_cr;
    bit          code_ack;
    bit          data_ack;
    bit          awaiting;
    logic [31:0] held;
    result_t     burst[$];
    result_t     due_results[$];
    int unsigned errors;

    function new();
      own_addr   = 8'd0;
      motor_addr = 8'd1;
      io_addr    = 8'd2;
      acc_code   = 32'd0;
      foreach (frame_bytes[k]) frame_bytes[k] = 8'd0;
      fill       = 0;
      text_mode  = 0;
      saw_cr     = 0;
      code_ack   = 0;
      data_ack   = 0;
      awaiting   = 0;
      held       = 32'd0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_OWN_ADDR:   own_addr = v[7:0];
        CFG_MOTOR_ADDR: motor_addr = v[7:0];
        CFG_IO_ADDR:    io_addr = v[7:0];
        CFG_ACC_CODE:   acc_code = v;
        default: ;
      endcase
    endfunction

    function void add(kind_e k, logic [7:0] t, logic [7:0] ad, logic [31:0] w,
                      logic [31:0] c, logic [31:0] d, err_e e);
      result_t r;
      r = '0;
      r.kind       = k;
      r.text_byte  = t;
      r.tx_addr    = ad;
      r.tx_word    = w;
      r.cmd_code   = c;
      r.cmd_data   = d;
      r.error_code = e;
      burst.push_back(r);
    endfunction

    function void drop_handshake();
      code_ack = 0;
      data_ack = 0;
      awaiting = 0;
      fill     = 0;
    endfunction

    function void decode_frame();
      logic [7:0]  a;
      logic [31:0] word;
      a    = frame_bytes[0];
      word = {frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4]};
      if (a == io_addr || a == motor_addr) return;
      if (a != own_addr) begin
        drop_handshake();
        add(KIND_ERROR, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, ERR_UNKNOWN_ADDR);
      end else if (word == CODE_ACK_WORD) begin
        if (code_ack) begin
          drop_handshake();
          add(KIND_ERROR, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, ERR_DUP_ACK);
        end else begin
          code_ack = 1;
          add(KIND_ACK, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, ERR_NONE);
        end
      end else if (word == DATA_ACK_WORD) begin
        if (data_ack) begin
          drop_handshake();
          add(KIND_ERROR, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, ERR_DUP_ACK);
        end else begin
          data_ack = 1;
          add(KIND_ACK, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, ERR_NONE);
        end
      end else if (!awaiting) begin
        if (word == acc_code) begin
          held     = word;
          awaiting = 1;
          add(KIND_SEND, 8'd0, motor_addr, CODE_ACK_WORD, 32'd0, 32'd0, ERR_NONE);
        end else begin
          drop_handshake();
          add(KIND_ERROR, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, ERR_CODE_REJ);
        end
      end else begin
        awaiting = 0;
        add(KIND_SEND, 8'd0, motor_addr, DATA_ACK_WORD, 32'd0, 32'd0, ERR_NONE);
        add(KIND_DELIVER, 8'd0, 8'd0, 32'd0, held, word, ERR_NONE);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      bit prefix;
      burst.delete();
      if (text_mode) begin
        if (b == CH_CR) begin
          saw_cr = 1;
        end else begin
          if (saw_cr && b == CH_LF) text_mode = 0;
          saw_cr = 0;
        end
        add(KIND_TEXT, b, 8'd0, 32'd0, 32'd0, 32'd0, ERR_NONE);
      end else begin
        if (fill >= FRAME_LEN) fill = 0;
        frame_bytes[fill] = b;
        fill++;
        if (fill >= FRAME_LEN) begin
          prefix = (frame_bytes[0] == PFX_A_0 && frame_bytes[1] == PFX_A_1 &&
                    frame_bytes[2] == PFX_A_2 && frame_bytes[3] == PFX_A_3) ||
                   (frame_bytes[0] == PFX_B_0 && frame_bytes[1] == PFX_B_1 &&
                    frame_bytes[2] == PFX_B_2 && frame_bytes[3] == PFX_B_3);
          if (prefix) begin
            text_mode = 1;
            foreach (frame_bytes[k])
              add(KIND_TEXT, frame_bytes[k], 8'd0, 32'd0, 32'd0, 32'd0, ERR_NONE);
          end else begin
            decode_frame();
          end
          fill = 0;
        end
      end
      foreach (burst[k]) begin
        burst[k].code_ack_seen = code_ack;
        burst[k].data_ack_seen = data_ack;
        burst[k].last          = (k == burst.size() - 1);
        due_results.push_back(burst[k]);
      end
    endfunction

    function string show(result_t r);
      return $sformatf("kind %0d text %h addr %h word %h code %h data %h err %0d ca %b da %b last %b",
                       r.kind, r.text_byte, r.tx_addr, r.tx_word, r.cmd_code, r.cmd_data,
                       r.error_code, r.code_ack_seen, r.data_ack_seen, r.last);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report({"result with nothing due: ", show(got)});
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.text_byte !== want.text_byte ||
          got.tx_addr !== want.tx_addr || got.tx_word !== want.tx_word ||
          got.cmd_code !== want.cmd_code || got.cmd_data !== want.cmd_data ||
          got.error_code !== want.error_code || got.code_ack_seen !== want.code_ack_seen ||
          got.data_ack_seen !== want.data_ack_seen || got.last !== want.last)
        report({"mismatch: expected ", show(want), " got ", show(got)});
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  sfhr_rx_if  rx_if ();
  sfhr_res_if res_if ();

  serial_frame_handshake_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  handshake_scoreboard sb;
  bit                  calm;
  int unsigned         bytes_sent;
  logic [7:0]          cfg_own;
  logic [7:0]          cfg_motor;
  logic [7:0]          cfg_io;
  logic [31:0]         cfg_acc;

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("serial_frame_handshake_receiver_tb failed");
    $finish;
  end

  initial begin
    int unsigned stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        res_if.ready <= 1'b1;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        stall = $urandom_range(1, 6) - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind          = res_if.kind;
      got.text_byte     = res_if.text_byte;
      got.tx_addr       = res_if.tx_addr;
      got.tx_word       = res_if.tx_word;
      got.cmd_code      = res_if.cmd_code;
      got.cmd_data      = res_if.cmd_data;
      got.error_code    = res_if.error_code;
      got.code_ack_seen = res_if.code_ack_seen;
      got.data_ack_seen = res_if.data_ack_seen;
      got.last          = res_if.last;
      sb.check_result(got);
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(logic [7:0] addr, logic [31:0] word);
    send_byte(addr);
    for (int k = 3; k >= 0; k--) send_byte(word[k*8 +: 8]);
  endtask

  task automatic send_text_run();
    logic [7:0] b;
    logic [7:0] prev;
    if ($urandom_range(0, 1))
      send_frame(PFX_A_0, {PFX_A_1, PFX_A_2, PFX_A_3, 8'($urandom)});
    else
      send_frame(PFX_B_0, {PFX_B_1, PFX_B_2, PFX_B_3, 8'($urandom)});
    prev = 8'h00;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 5))
        0:       b = CH_CR;
        1:       b = CH_LF;
        default: b = 8'($urandom);
      endcase
      // keep the run open until the closing pair
      if (prev == CH_CR && b == CH_LF) b = CH_CR;
      send_byte(b);
      prev = b;
    end
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic run_random(int unsigned target);
    logic [7:0]  a;
    logic [31:0] w;
    while (bytes_sent < target) begin
      w = $urandom;
      case ($urandom_range(0, 15))
        0, 1: send_frame(cfg_own, CODE_ACK_WORD);
        2, 3: send_frame(cfg_own, DATA_ACK_WORD);
        4, 5, 6: begin
          send_frame(cfg_own, cfg_acc);
          send_frame(cfg_own, w);
        end
        7: send_frame(cfg_own, w);
        8: send_frame(cfg_io, w);
        9: send_frame(cfg_motor, w);
        10: begin
          do a = 8'($urandom); while (a == cfg_own || a == cfg_io || a == cfg_motor);
          send_frame(a, w);
        end
        11, 12: send_text_run();
        13: send_frame(PFX_A_0, {PFX_A_1, PFX_A_2, ~PFX_A_3, w[7:0]});
        14: send_frame(8'($urandom), w);
        default: begin
          case ($urandom_range(0, 3))
            0:       w = 32'h8000_0000;
            1:       w = 32'h7FFF_FFFE;
            2:       w = '1;
            default: w = '0;
          endcase
          send_frame(cfg_own, cfg_acc);
          send_frame(cfg_own, w);
        end
      endcase
    end
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [7:0] own, logic [7:0] motor, logic [7:0] io,
                             logic [31:0] acc);
    cfg_own   = own;
    cfg_motor = motor;
    cfg_io    = io;
    cfg_acc   = acc;
    write_reg(CFG_OWN_ADDR, {24'd0, own});
    write_reg(CFG_MOTOR_ADDR, {24'd0, motor});
    write_reg(CFG_IO_ADDR, {24'd0, io});
    write_reg(CFG_ACC_CODE, acc);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_OWN_ADDR;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    calm          = 0;
    bytes_sent    = 0;
    sb            = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    load_config(8'h10, 8'h20, 8'h30, 32'h1234_5678);
    send_frame(cfg_own, cfg_acc);
    send_frame(cfg_own, 32'h8000_0000);
    send_frame(cfg_own, CODE_ACK_WORD);
    send_frame(cfg_own, CODE_ACK_WORD);
    send_frame(PFX_A_0, {PFX_A_1, PFX_A_2, PFX_A_3, 8'hFF});
    send_byte(CH_CR);
    send_byte(CH_LF);
    run_random(bytes_sent + PHASE_BYTES);
    settle();

    load_config(8'h00, 8'hFF, 8'h01, 32'hFFFF_FFFF);
    run_random(bytes_sent + PHASE_BYTES);
    settle();

    load_config(8'hFF, 8'h00, 8'h80, 32'h0000_0000);
    run_random(bytes_sent + PHASE_BYTES);
    settle();

    load_config(8'($urandom), 8'($urandom), 8'($urandom), $urandom);
    calm = 1;
    run_random(bytes_sent + PHASE_BYTES);
    settle();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("serial_frame_handshake_receiver_tb passed");
    else
      $display("serial_frame_handshake_receiver_tb failed");
    $finish;
  end

endmodule
